[rtl/mhpq_pkg.sv]
// Shared types and constants of the max-heap priority queue.
`default_nettype none

package mhpq_pkg;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned TAG_W   = 16;

	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	// one classified item from the front queue
	typedef struct packed {
		logic   valid;
		op_t    op;
		entry_t entry;
	} itm_t;

	typedef struct packed {
		status_t status;
		entry_t  entry;
		logic    now_empty;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_REQ,
		S_UP_CMP,
		S_EX_ROOT,
		S_EX_LAST,
		S_DN_LREQ,
		S_DN_LCMP,
		S_DN_RCMP
	} state_t;

	// signed compare of two raw key patterns: a > b
	function automatic logic key_gt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		return $signed(a) > $signed(b);
	endfunction

endpackage

`default_nettype wire

[rtl/mhpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mhpq_ram #(
	parameter int unsigned WIDTH = 80,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/mhpq_front.sv]
// Front end: two-entry input queue that accepts and classifies items.
`default_nettype none

module mhpq_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic                                cmd,
	input  wire logic [mhpq_pkg::KEY_W-1:0]          key,
	input  wire logic [mhpq_pkg::VALUE_W-1:0]        value,
	input  wire logic [mhpq_pkg::TAG_W-1:0]          tag,
	output mhpq_pkg::itm_t                           itm,
	input  wire logic                                take
);
	import mhpq_pkg::*;

	typedef struct packed {
		op_t    op;
		entry_t entry;
	} slot_t;

	slot_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;
	slot_t      in_slot;

	assign full    = (cnt_q == 2'd2);
	assign do_push = push & ~full;
	assign do_pop  = take & (cnt_q != 2'd0);

	always_comb begin
		in_slot.op          = op_t'(cmd);
		in_slot.entry.key   = key;
		in_slot.entry.value = value;
		in_slot.entry.tag   = tag;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= in_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_comb begin
		itm.valid = (cnt_q != 2'd0);
		itm.op    = slot_q[rd_ptr_q].op;
		itm.entry = slot_q[rd_ptr_q].entry;
	end

endmodule

`default_nettype wire

[rtl/mhpq_engine.sv]
// Back end: heap sequencer over the entry RAM, with a one-entry result register.
`default_nettype none

module mhpq_engine #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mhpq_pkg::itm_t itm,
	output logic                take,
	output logic                res_valid,
	input  wire logic           pop,
	output mhpq_pkg::res_t      res
);
	import mhpq_pkg::*;

	localparam int unsigned ADDR_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned IDX_W  = ADDR_W + 1;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	entry_t            mov_q, mov_d;
	entry_t            root_q, root_d;
	entry_t            best_q, best_d;
	logic              best_child_q, best_child_d;
	logic              res_valid_q;
	res_t              res_q;
	logic              res_load;
	res_t              res_d;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            rd_entry;

	logic [ADDR_W-1:0] parent;
	logic [IDX_W-1:0]  lc_w;
	logic [IDX_W-1:0]  rc_w;
	logic [IDX_W-1:0]  count_ext;
	logic              lc_ok;
	logic              rc_ok;
	logic              heap_full;
	logic              can_start;
	logic              lgt;
	logic              rgt;

	mhpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry  = entry_t'(ram_rdata);
	assign parent    = (pos_q - ADDR_W'(1)) >> 1;
	assign lc_w      = {pos_q, 1'b1};
	assign rc_w      = lc_w + IDX_W'(1);
	assign count_ext = IDX_W'(count_q);
	assign lc_ok     = (lc_w < count_ext);
	assign rc_ok     = (rc_w < count_ext);
	assign heap_full = (count_q == CNT_W'(CAPACITY));
	assign can_start = itm.valid & ~res_valid_q;
	assign lgt       = key_gt(rd_entry.key, mov_q.key);
	assign rgt       = key_gt(rd_entry.key, best_q.key);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (can_start) begin
					if (itm.op == OP_INSERT) begin
						if (!heap_full) begin
							state_d = S_UP_REQ;
						end
					end else if (count_q != '0) begin
						state_d = S_EX_ROOT;
					end
				end
			end
			S_UP_REQ: begin
				state_d = (pos_q == '0) ? S_IDLE : S_UP_CMP;
			end
			S_UP_CMP: begin
				state_d = lgt ? S_IDLE : S_UP_REQ;
			end
			S_EX_ROOT: begin
				state_d = S_EX_LAST;
			end
			S_EX_LAST: begin
				state_d = (count_q == CNT_W'(1)) ? S_IDLE : S_DN_LREQ;
			end
			S_DN_LREQ: begin
				state_d = lc_ok ? S_DN_LCMP : S_IDLE;
			end
			S_DN_LCMP: begin
				if (rc_ok) begin
					state_d = S_DN_RCMP;
				end else begin
					state_d = lgt ? S_DN_LREQ : S_IDLE;
				end
			end
			S_DN_RCMP: begin
				state_d = (rgt || best_child_q) ? S_DN_LREQ : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: RAM control, datapath loads and result
	always_comb begin
		take         = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = pos_q;
		ram_wdata    = mov_q;
		ram_raddr    = '0;
		count_d      = count_q;
		pos_d        = pos_q;
		mov_d        = mov_q;
		root_d       = root_q;
		best_d       = best_q;
		best_child_d = best_child_q;
		res_load     = 1'b0;
		res_d.status    = ST_OK;
		res_d.entry     = '0;
		res_d.now_empty = (count_q == '0);
		unique case (state_q)
			S_IDLE: begin
				if (can_start) begin
					take = 1'b1;
					if (itm.op == OP_INSERT) begin
						if (heap_full) begin
							res_load     = 1'b1;
							res_d.status = ST_FULL;
						end else begin
							mov_d   = itm.entry;
							pos_d   = count_q[ADDR_W-1:0];
							count_d = count_q + CNT_W'(1);
						end
					end else if (count_q == '0) begin
						res_load     = 1'b1;
						res_d.status = ST_EMPTY;
					end
				end
			end
			S_UP_REQ: begin
				if (pos_q == '0) begin
					ram_we   = 1'b1;
					res_load = 1'b1;
				end else begin
					ram_raddr = parent;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (lgt) begin
					res_load = 1'b1;
				end else begin
					// pull the parent down into the hole and climb
					ram_wdata = rd_entry;
					pos_d     = parent;
				end
			end
			S_EX_ROOT: begin
				root_d    = rd_entry;
				ram_raddr = ADDR_W'(count_q - CNT_W'(1));
			end
			S_EX_LAST: begin
				mov_d   = rd_entry;
				count_d = count_q - CNT_W'(1);
				pos_d   = '0;
				if (count_q == CNT_W'(1)) begin
					res_load        = 1'b1;
					res_d.entry     = root_q;
					res_d.now_empty = 1'b1;
				end
			end
			S_DN_LREQ: begin
				if (lc_ok) begin
					ram_raddr = lc_w[ADDR_W-1:0];
				end else begin
					ram_we      = 1'b1;
					res_load    = 1'b1;
					res_d.entry = root_q;
				end
			end
			S_DN_LCMP: begin
				best_d       = lgt ? rd_entry : mov_q;
				best_child_d = lgt;
				if (rc_ok) begin
					ram_raddr = rc_w[ADDR_W-1:0];
				end else begin
					ram_we = 1'b1;
					if (lgt) begin
						ram_wdata = rd_entry;
						pos_d     = lc_w[ADDR_W-1:0];
					end else begin
						res_load    = 1'b1;
						res_d.entry = root_q;
					end
				end
			end
			S_DN_RCMP: begin
				ram_we = 1'b1;
				if (rgt) begin
					ram_wdata = rd_entry;
					pos_d     = rc_w[ADDR_W-1:0];
				end else if (best_child_q) begin
					ram_wdata = best_q;
					pos_d     = lc_w[ADDR_W-1:0];
				end else begin
					res_load    = 1'b1;
					res_d.entry = root_q;
				end
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		pos_q        <= pos_d;
		mov_q        <= mov_d;
		root_q       <= root_d;
		best_q       <= best_d;
		best_child_q <= best_child_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

[rtl/max_heap_priority_queue.sv]
// Top level of the binary max-heap priority queue: front queue and heap engine.
// Insert, once it leaves the front queue, sifts up level by level: a parent read,
// then a compare and write, using the RAM's single read port.
// Extract reads the root and the last entry, then sifts down level by level:
// a left read, a right read, then a compare and write.
// Refused items go straight to the result; one item runs at a time, the next only after a pop.
// Reset clears the entry count and all control; heap RAM contents are not cleared.
`default_nettype none

module max_heap_priority_queue #(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input item queue side
	input  wire logic               push,
	output logic                    full,
	input  wire logic               cmd,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] value,
	input  wire logic        [15:0] tag,
	// result queue side
	output logic                    empty,
	input  wire logic               pop,
	output logic             [1:0]  status,
	output logic signed      [31:0] out_key,
	output logic signed      [31:0] out_value,
	output logic             [15:0] out_tag,
	output logic                    now_empty
);
	import mhpq_pkg::*;

	itm_t itm;
	logic take;
	logic res_valid;
	res_t res;

	// Front: buffer up to two items so the host keeps pushing while the heap works
	mhpq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.cmd    (cmd),
		.key    (key),
		.value  (value),
		.tag    (tag),
		.itm    (itm),
		.take   (take)
	);

	// Back: run one item at a time; hold its result until popped
	mhpq_engine #(
		.CAPACITY (CAPACITY)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.itm       (itm),
		.take      (take),
		.res_valid (res_valid),
		.pop       (pop),
		.res       (res)
	);

	// Drive the result ports straight from the result register
	assign empty     = ~res_valid;
	assign status    = res.status;
	assign out_key   = res.entry.key;
	assign out_value = res.entry.value;
	assign out_tag   = res.entry.tag;
	assign now_empty = res.now_empty;

endmodule

`default_nettype wire
